FILE: design/adx_pkg.sv
// Shared widths, register codes and reset values of the ADX block.
package adx_pkg;

  localparam int unsigned MAX_PERIOD_DEF = 1024;
  localparam int unsigned MIN_PERIOD     = 2;

  localparam int unsigned PRICE_W  = 32;
  localparam int unsigned SUM_W    = 48;
  localparam int unsigned ACC_W    = 40;
  localparam int unsigned ADX_W    = 23;
  localparam int unsigned PERIOD_W = 11;
  localparam int unsigned INV_W    = 24;
  localparam int unsigned HALF_W   = 24;   // split of a sum into multiplier halves
  localparam int unsigned QUOT_W   = 24;   // divider quotient bits
  localparam int unsigned DX_FRAC  = 17;   // extra quotient bits past the integer part
  localparam int unsigned DIV_W    = SUM_W + 1;
  localparam int unsigned NUM_W    = SUM_W + 7;

  localparam logic [ADX_W-1:0]    DX_FULL      = ADX_W'(6553600);
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(14);
  localparam logic [INV_W-1:0]    INV_RESET    = INV_W'(1198373);

  // APB register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;
  localparam logic REG_PERIOD  = 1'b0;
  localparam logic REG_INVERSE = 1'b1;

  typedef enum logic [1:0] {
    TGT_PLUS  = 2'd0,
    TGT_MINUS = 2'd1,
    TGT_ACC   = 2'd2,
    TGT_OUT   = 2'd3
  } tgt_e;

endpackage

FILE: design/adx_if.sv
// Valid/ready channel interfaces for price bars in and ADX results out.
interface adx_in_if;
  logic                           valid;
  logic                           ready;
  logic                           restart;
  logic [adx_pkg::PRICE_W-1:0]    high_price;
  logic [adx_pkg::PRICE_W-1:0]    low_price;

  modport source (output valid, output restart, output high_price, output low_price,
                  input ready);
  modport sink   (input valid, input restart, input high_price, input low_price,
                  output ready);
endinterface

interface adx_out_if;
  logic                           valid;
  logic                           ready;
  logic [adx_pkg::ADX_W-1:0]      adx_value;
  logic                           flat_seen;

  modport source (output valid, output adx_value, output flat_seen, input ready);
  modport sink   (input valid, input adx_value, input flat_seen, output ready);
endinterface

FILE: design/adx_div.sv
// Restoring serial divider, one quotient bit per cycle, for the DX ratio.
module adx_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [adx_pkg::NUM_W-1:0]    num_i,
  input  logic [adx_pkg::DIV_W-1:0]    den_i,
  output logic                         done_o,
  output logic [adx_pkg::QUOT_W-1:0]   quot_o
);

  localparam int unsigned SHIFT_IN = adx_pkg::QUOT_W - adx_pkg::DX_FRAC;
  localparam int unsigned CNT_W    = $clog2(adx_pkg::QUOT_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(adx_pkg::QUOT_W - 1);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [adx_pkg::DIV_W-1:0]   rem_q, rem_d;
  logic [adx_pkg::DIV_W-1:0]   den_q, den_d;
  logic [adx_pkg::QUOT_W-1:0]  low_q, low_d;
  logic [adx_pkg::QUOT_W-1:0]  quot_q, quot_d;
  logic [adx_pkg::DIV_W:0]     trial;
  logic [adx_pkg::DIV_W:0]     trial_sub;
  logic                        ge;

  assign trial     = {rem_q, low_q[adx_pkg::QUOT_W-1]};
  assign trial_sub = trial - {1'b0, den_q};
  assign ge        = !trial_sub[adx_pkg::DIV_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    low_d  = low_q;
    quot_d = quot_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      den_d  = den_i;
      // the leading part is already below the divisor
      rem_d  = adx_pkg::DIV_W'(num_i[adx_pkg::NUM_W-1:SHIFT_IN]);
      low_d  = {num_i[SHIFT_IN-1:0], {adx_pkg::DX_FRAC{1'b0}}};
      quot_d = '0;
    end else if (busy_q) begin
      rem_d  = ge ? trial_sub[adx_pkg::DIV_W-1:0] : trial[adx_pkg::DIV_W-1:0];
      quot_d = {quot_q[adx_pkg::QUOT_W-2:0], ge};
      low_d  = {low_q[adx_pkg::QUOT_W-2:0], 1'b0};
      cnt_d  = cnt_q + CNT_W'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    low_q  <= low_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

FILE: design/average_directional_index.sv
// Bars are taken one at a time; the 24-step serial divider and the shared 24x24 multiplier
// (two passes per Wilder decay) set how long each bar takes. Not ready while busy, nor while
// a finished result waits for the previous one to leave the output register.
// Reset: asynchronous, active low; period 14, inverse 1198373, sample count zero,
// so the first bar after reset starts a series. No clearing pass.
module average_directional_index #(
  parameter int unsigned MAX_PERIOD = adx_pkg::MAX_PERIOD_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  adx_in_if.sink                       in_i,
  adx_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [adx_pkg::PADDR_W-1:0]  paddr,
  input  logic [adx_pkg::PDATA_W-1:0]  pwdata,
  output logic [adx_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  localparam int unsigned CNT_W = $clog2(2 * MAX_PERIOD);
  localparam int unsigned EW    =
      ((CNT_W > adx_pkg::PERIOD_W) ? CNT_W : adx_pkg::PERIOD_W) + 1;
  localparam logic [CNT_W-1:0] COUNT_MAX = CNT_W'(2 * MAX_PERIOD - 1);
  localparam int unsigned SW = adx_pkg::SUM_W;
  localparam int unsigned AW = adx_pkg::ACC_W;
  localparam int unsigned HW = adx_pkg::HALF_W;
  localparam logic [SW:0] ROUND_HALF = (SW + 1)'(1) << (HW - 1);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_MOVE   = 13'b0000000000010,
    S_SUMS   = 13'b0000000000100,
    S_MHI    = 13'b0000000001000,
    S_MLO    = 13'b0000000010000,
    S_SCALE  = 13'b0000000100000,
    S_APPLY  = 13'b0000001000000,
    S_DXSET  = 13'b0000010000000,
    S_DXMUL  = 13'b0000100000000,
    S_DIV    = 13'b0001000000000,
    S_DXDONE = 13'b0010000000000,
    S_ACCADD = 13'b0100000000000,
    S_OUT    = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;
  adx_pkg::tgt_e tgt_q, tgt_d;

  // configuration
  logic [adx_pkg::PERIOD_W-1:0] period_q;
  logic [adx_pkg::INV_W-1:0]    inv_q;
  logic                         cfg_wr;

  // series state
  logic [adx_pkg::PRICE_W-1:0]  prev_hi_q, prev_lo_q;
  logic [SW-1:0]                plus_q, minus_q;
  logic [AW-1:0]                acc_q;
  logic [CNT_W-1:0]             count_q;

  // per-bar working registers
  logic                         restart_q;
  logic [adx_pkg::PRICE_W-1:0]  hi_q, lo_q;
  logic [adx_pkg::PRICE_W-1:0]  pdm_q, mdm_q;
  logic                         warm_q, last_q, fill_q, steady_q;
  logic [SW-1:0]                prod_q, part_q, scaled_q;
  logic [adx_pkg::DIV_W-1:0]    sum_q;
  logic [SW-1:0]                diff_q;
  logic [adx_pkg::ADX_W-1:0]    dx_q;
  logic                         flat_q;

  // output register
  logic                         out_valid_q;
  logic [adx_pkg::ADX_W-1:0]    out_adx_q;
  logic                         out_flat_q;
  logic                         out_free;

  // combinational helpers
  logic [EW-1:0]                p_ext, p_cl, i_ext, p_m1, two_p2;
  logic                         first_bar;
  logic [adx_pkg::PRICE_W:0]    up, down;
  logic [SW-1:0]                opnd;
  logic [HW-1:0]                mul_a;
  logic [SW:0]                  round_sum;
  logic [SW:0]                  dec_sub;
  logic [SW-1:0]                dec;
  logic [SW:0]                  plus_add, minus_add;
  logic [AW:0]                  acc_add;
  logic [SW:0]                  ud_sub, du_sub;
  logic [adx_pkg::NUM_W-1:0]    diff_ext, num;
  logic                         div_start, div_done;
  logic [adx_pkg::QUOT_W-1:0]   quot;
  logic [adx_pkg::QUOT_W:0]     quot_inc;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == adx_pkg::REG_INVERSE) ?
                  adx_pkg::PDATA_W'(inv_q) : adx_pkg::PDATA_W'(period_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= adx_pkg::PERIOD_RESET;
      inv_q    <= adx_pkg::INV_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == adx_pkg::REG_PERIOD) begin
        period_q <= pwdata[adx_pkg::PERIOD_W-1:0];
      end else begin
        inv_q <= pwdata[adx_pkg::INV_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------- phase
  assign p_ext  = EW'(period_q);
  assign p_cl   = (p_ext < EW'(adx_pkg::MIN_PERIOD)) ? EW'(adx_pkg::MIN_PERIOD) :
                  (p_ext > EW'(MAX_PERIOD)) ? EW'(MAX_PERIOD) : p_ext;
  assign i_ext  = EW'(count_q);
  assign p_m1   = p_cl - EW'(1);
  assign two_p2 = (p_cl << 1) - EW'(2);

  assign first_bar = restart_q || (count_q == '0);
  assign up   = {1'b0, hi_q} - {1'b0, prev_hi_q};
  assign down = {1'b0, prev_lo_q} - {1'b0, lo_q};

  // ---------------------------------------------------------------- datapath
  always_comb begin
    unique case (tgt_q)
      adx_pkg::TGT_PLUS:  opnd = plus_q;
      adx_pkg::TGT_MINUS: opnd = minus_q;
      default:            opnd = SW'(acc_q);
    endcase
  end

  assign mul_a     = (state_q == S_MHI) ? opnd[SW-1:HW] : opnd[HW-1:0];
  assign round_sum = {1'b0, prod_q} + ROUND_HALF;
  // the decay never takes a sum below zero
  assign dec_sub   = {1'b0, opnd} - {1'b0, scaled_q};
  assign dec       = dec_sub[SW] ? '0 : dec_sub[SW-1:0];

  assign plus_add  = {1'b0, plus_q} + (SW + 1)'(pdm_q);
  assign minus_add = {1'b0, minus_q} + (SW + 1)'(mdm_q);
  assign acc_add   = {1'b0, acc_q} + (AW + 1)'(dx_q);

  assign ud_sub = {1'b0, plus_q} - {1'b0, minus_q};
  assign du_sub = {1'b0, minus_q} - {1'b0, plus_q};

  // times one hundred as three shifted terms
  assign diff_ext = adx_pkg::NUM_W'(diff_q);
  assign num      = (diff_ext << 6) + (diff_ext << 5) + (diff_ext << 2);
  assign div_start = (state_q == S_DXMUL) && (sum_q != '0);
  assign quot_inc  = {1'b0, quot} + (adx_pkg::QUOT_W + 1)'(1);

  adx_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (sum_q),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  assign out_free = !out_valid_q || out_o.ready;

  // ---------------------------------------------------------------- sequencer
  always_comb begin
    state_d = state_q;
    tgt_d   = tgt_q;
    unique case (state_q)
      S_IDLE:   if (in_i.valid) state_d = S_MOVE;
      S_MOVE: begin
        if (first_bar) begin
          state_d = S_IDLE;
        end else if (i_ext < p_cl) begin
          state_d = S_SUMS;
        end else begin
          tgt_d   = adx_pkg::TGT_PLUS;
          state_d = S_MHI;
        end
      end
      S_SUMS:   state_d = (warm_q && !last_q) ? S_IDLE : S_DXSET;
      S_MHI:    state_d = S_MLO;
      S_MLO:    state_d = S_SCALE;
      S_SCALE:  state_d = (tgt_q == adx_pkg::TGT_OUT) ? S_OUT : S_APPLY;
      S_APPLY: begin
        unique case (tgt_q)
          adx_pkg::TGT_PLUS: begin
            tgt_d   = adx_pkg::TGT_MINUS;
            state_d = S_MHI;
          end
          adx_pkg::TGT_MINUS: state_d = S_SUMS;
          default:            state_d = S_ACCADD;
        endcase
      end
      S_DXSET:  state_d = S_DXMUL;
      S_DXMUL:  state_d = (sum_q == '0) ? S_DXDONE : S_DIV;
      S_DIV:    if (div_done) state_d = S_DXDONE;
      S_DXDONE: begin
        priority if (last_q) begin
          state_d = S_IDLE;
        end else if (steady_q) begin
          tgt_d   = adx_pkg::TGT_ACC;
          state_d = S_MHI;
        end else begin
          state_d = S_ACCADD;
        end
      end
      S_ACCADD: begin
        if (fill_q) begin
          state_d = S_IDLE;
        end else begin
          tgt_d   = adx_pkg::TGT_OUT;
          state_d = S_MHI;
        end
      end
      S_OUT:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tgt_q       <= adx_pkg::TGT_PLUS;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tgt_q   <= tgt_d;
      if (state_q == S_MOVE) begin
        if (first_bar) begin
          count_q <= CNT_W'(1);
        end else if (count_q != COUNT_MAX) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if ((state_q == S_OUT) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- payload
  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_i.valid) begin
      restart_q <= in_i.restart;
      hi_q      <= in_i.high_price;
      lo_q      <= in_i.low_price;
    end

    if (state_q == S_MOVE) begin
      prev_hi_q <= hi_q;
      prev_lo_q <= lo_q;
      if (first_bar) begin
        plus_q  <= '0;
        minus_q <= '0;
        acc_q   <= '0;
      end
      pdm_q    <= (!up[adx_pkg::PRICE_W] && (up != '0) &&
                   ($signed(up) > $signed(down))) ? up[adx_pkg::PRICE_W-1:0] : '0;
      mdm_q    <= (!down[adx_pkg::PRICE_W] && (down != '0) &&
                   ($signed(down) > $signed(up))) ? down[adx_pkg::PRICE_W-1:0] : '0;
      warm_q   <= i_ext < p_cl;
      last_q   <= i_ext == p_m1;
      fill_q   <= (i_ext >= p_cl) && (i_ext < two_p2);
      steady_q <= i_ext > two_p2;
    end

    // shared multiplier: high half first, then low half
    if ((state_q == S_MHI) || (state_q == S_MLO)) begin
      prod_q <= SW'(mul_a) * SW'(inv_q);
    end
    if (state_q == S_MLO) begin
      part_q <= prod_q;
    end
    if (state_q == S_SCALE) begin
      scaled_q <= part_q + SW'(round_sum[SW:HW]);
    end

    if (state_q == S_APPLY) begin
      unique case (tgt_q)
        adx_pkg::TGT_PLUS:  plus_q  <= dec;
        adx_pkg::TGT_MINUS: minus_q <= dec;
        default:            acc_q   <= dec[AW-1:0];
      endcase
    end

    if (state_q == S_SUMS) begin
      plus_q  <= plus_add[SW]  ? '1 : plus_add[SW-1:0];
      minus_q <= minus_add[SW] ? '1 : minus_add[SW-1:0];
    end

    if (state_q == S_DXSET) begin
      sum_q  <= {1'b0, plus_q} + {1'b0, minus_q};
      diff_q <= ud_sub[SW] ? du_sub[SW-1:0] : ud_sub[SW-1:0];
    end

    if (state_q == S_DXMUL) begin
      flat_q <= (sum_q == '0);
      dx_q   <= '0;
    end
    if ((state_q == S_DIV) && div_done) begin
      dx_q <= quot_inc[adx_pkg::ADX_W:1];
    end

    if ((state_q == S_DXDONE) && last_q) begin
      acc_q <= AW'(dx_q);
    end
    if (state_q == S_ACCADD) begin
      acc_q <= acc_add[AW] ? '1 : acc_add[AW-1:0];
    end

    if ((state_q == S_OUT) && out_free) begin
      out_adx_q  <= (scaled_q > SW'(adx_pkg::DX_FULL)) ?
                    adx_pkg::DX_FULL : scaled_q[adx_pkg::ADX_W-1:0];
      out_flat_q <= flat_q;
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.adx_value = out_adx_q;
  assign out_o.flat_seen = out_flat_q;

endmodule

FILE: dv/tb_average_directional_index.sv
// Self-checking testbench for the ADX block: price bars in, predicted ADX results checked.
`timescale 1ns / 1ps

module tb_average_directional_index;

  typedef struct packed {
    logic [adx_pkg::ADX_W-1:0] adx_value;
    logic                      flat_seen;
  } adx_result_t;

  localparam logic [63:0] SUM_LIMIT     = (64'd1 << adx_pkg::SUM_W) - 64'd1;
  localparam logic [63:0] ACC_LIMIT     = (64'd1 << adx_pkg::ACC_W) - 64'd1;
  localparam int unsigned COUNT_LIMIT   = 2 * adx_pkg::MAX_PERIOD_DEF - 1;
  localparam int unsigned SETTLE_CYCLES = 64;
  localparam int unsigned MAX_REPORTS   = 10;

  logic                        clk;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [adx_pkg::PADDR_W-1:0] paddr;
  logic [adx_pkg::PDATA_W-1:0] pwdata;
  logic [adx_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  adx_in_if  bar_if ();
  adx_out_if res_if ();

  average_directional_index i_dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (bar_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the configuration and series state
  logic [adx_pkg::PERIOD_W-1:0] cfg_period;
  logic [adx_pkg::INV_W-1:0]    cfg_inverse;
  logic [adx_pkg::PRICE_W-1:0]  last_high;
  logic [adx_pkg::PRICE_W-1:0]  last_low;
  logic [63:0]                  plus_dm_sum;
  logic [63:0]                  minus_dm_sum;
  logic [63:0]                  dx_accum;
  int unsigned                  bar_index;

  adx_result_t adx_expected_q[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Price walk used by the random series
  longint                      walk_mid   = 64'sd2147483648;
  longint                      walk_drift = 0;
  logic [adx_pkg::PRICE_W-1:0] walk_high  = '0;
  logic [adx_pkg::PRICE_W-1:0] walk_low   = '0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void note_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s", $time, what);
    end
  endfunction

  // round(v * inverse / 2^24), split so that no product overflows
  function automatic logic [63:0] mul_inverse(input logic [63:0] v,
                                              input logic [adx_pkg::INV_W-1:0] inv);
    logic [63:0] upper;
    logic [63:0] lower;
    upper = v >> 24;
    lower = v & 64'hFF_FFFF;
    return upper * inv + ((lower * inv + 64'h80_0000) >> 24);
  endfunction

  function automatic logic [63:0] wilder_decay(input logic [63:0] v);
    logic [63:0] cut;
    cut = mul_inverse(v, cfg_inverse);
    return (cut > v) ? 64'd0 : v - cut;
  endfunction

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b,
                                          input logic [63:0] limit);
    logic [63:0] total;
    total = a + b;
    return (total > limit) ? limit : total;
  endfunction

  // DX in Q7.16, rounded half up from a quotient with one extra fraction bit
  function automatic logic [adx_pkg::ADX_W-1:0] dx_q716(input logic [63:0] plus_s,
                                                        input logic [63:0] minus_s,
                                                        output logic flat);
    logic [63:0] total;
    logic [63:0] spread;
    logic [79:0] num;
    logic [79:0] quot;
    total  = plus_s + minus_s;
    spread = (plus_s > minus_s) ? plus_s - minus_s : minus_s - plus_s;
    flat   = (total == 64'd0);
    if (flat) begin
      return '0;
    end
    num  = spread * 64'd100;
    num  = num << adx_pkg::DX_FRAC;
    quot = num / {16'd0, total};
    return adx_pkg::ADX_W'((quot + 80'd1) >> 1);
  endfunction

  task automatic predict_bar(input logic restart, input logic [adx_pkg::PRICE_W-1:0] hi,
                             input logic [adx_pkg::PRICE_W-1:0] lo);
    int unsigned p;
    int unsigned i;
    longint      up_move;
    longint      down_move;
    logic [63:0] plus_dm;
    logic [63:0] minus_dm;
    logic [63:0] adx_scaled;
    logic [adx_pkg::ADX_W-1:0] dx;
    logic        flat;
    adx_result_t res;
    p = (cfg_period < adx_pkg::MIN_PERIOD) ? adx_pkg::MIN_PERIOD :
        ((cfg_period > adx_pkg::MAX_PERIOD_DEF) ? adx_pkg::MAX_PERIOD_DEF : cfg_period);
    i = bar_index;
    flat = 1'b0;
    if (restart || i == 0) begin
      last_high    = hi;
      last_low     = lo;
      plus_dm_sum  = '0;
      minus_dm_sum = '0;
      dx_accum     = '0;
      bar_index    = 1;
      return;
    end
    up_move   = longint'({32'd0, hi}) - longint'({32'd0, last_high});
    down_move = longint'({32'd0, last_low}) - longint'({32'd0, lo});
    plus_dm   = (up_move > down_move && up_move > 0) ? 64'(up_move) : 64'd0;
    minus_dm  = (down_move > up_move && down_move > 0) ? 64'(down_move) : 64'd0;
    last_high = hi;
    last_low  = lo;
    bar_index = (i + 1 > COUNT_LIMIT) ? COUNT_LIMIT : i + 1;
    // plain sums while the first period fills
    if (i < p) begin
      plus_dm_sum  = sat_add(plus_dm_sum, plus_dm, SUM_LIMIT);
      minus_dm_sum = sat_add(minus_dm_sum, minus_dm, SUM_LIMIT);
      if (i == p - 1) begin
        dx_accum = 64'(dx_q716(plus_dm_sum, minus_dm_sum, flat));
      end
      return;
    end
    plus_dm_sum  = sat_add(wilder_decay(plus_dm_sum), plus_dm, SUM_LIMIT);
    minus_dm_sum = sat_add(wilder_decay(minus_dm_sum), minus_dm, SUM_LIMIT);
    dx = dx_q716(plus_dm_sum, minus_dm_sum, flat);
    if (i < 2 * p - 2) begin
      dx_accum = sat_add(dx_accum, 64'(dx), ACC_LIMIT);
      return;
    end
    if (i == 2 * p - 2) begin
      dx_accum = sat_add(dx_accum, 64'(dx), ACC_LIMIT);
    end else begin
      dx_accum = sat_add(wilder_decay(dx_accum), 64'(dx), ACC_LIMIT);
    end
    adx_scaled = mul_inverse(dx_accum, cfg_inverse);
    if (adx_scaled > 64'(adx_pkg::DX_FULL)) begin
      adx_scaled = 64'(adx_pkg::DX_FULL);
    end
    res.adx_value = adx_scaled[adx_pkg::ADX_W-1:0];
    res.flat_seen = flat;
    adx_expected_q.push_back(res);
  endtask

  always @(posedge clk) begin : adx_check
    adx_result_t seen;
    adx_result_t want;
    if (rst_n && res_if.valid === 1'b1 && res_if.ready) begin
      seen.adx_value = res_if.adx_value;
      seen.flat_seen = res_if.flat_seen;
      if (adx_expected_q.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: adx_value %0d flat_seen %0b",
                                seen.adx_value, seen.flat_seen));
      end else begin
        want = adx_expected_q.pop_front();
        if (seen.adx_value !== want.adx_value) begin
          note_mismatch($sformatf("adx_value expected %0d got %0d",
                                  want.adx_value, seen.adx_value));
        end
        if (seen.flat_seen !== want.flat_seen) begin
          note_mismatch($sformatf("flat_seen expected %0b got %0b",
                                  want.flat_seen, seen.flat_seen));
        end
      end
    end
  end

  function automatic void set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endfunction

  task automatic send_bar(input logic restart, input logic [adx_pkg::PRICE_W-1:0] hi,
                          input logic [adx_pkg::PRICE_W-1:0] lo,
                          input bit hold_for_results = 1'b0);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) begin
      gap++;
    end
    @(negedge clk);
    if (gap != 0 || hold_for_results) begin
      bar_if.valid <= 1'b0;
      while (hold_for_results && adx_expected_q.size() != 0) begin
        @(posedge clk);
      end
      repeat ((gap == 0) ? 1 : gap) @(negedge clk);
    end
    bar_if.valid      <= 1'b1;
    bar_if.restart    <= restart;
    bar_if.high_price <= hi;
    bar_if.low_price  <= lo;
    do @(posedge clk); while (bar_if.ready !== 1'b1);
    predict_bar(restart, hi, lo);
  endtask

  // Drop valid, wait for every result, then let a bar with no result finish
  task automatic settle_block();
    @(negedge clk);
    bar_if.valid <= 1'b0;
    while (adx_expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [adx_pkg::PDATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (reg_sel == adx_pkg::REG_PERIOD) begin
      cfg_period = value[adx_pkg::PERIOD_W-1:0];
    end else begin
      cfg_inverse = value[adx_pkg::INV_W-1:0];
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic apb_read_check(input logic reg_sel,
                                input logic [adx_pkg::PDATA_W-1:0] want);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {reg_sel, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== want) begin
      note_mismatch($sformatf("register %0d read %0h, expected %0h", reg_sel, prdata, want));
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_config(input logic [adx_pkg::PERIOD_W-1:0] period_value,
                            input logic [adx_pkg::INV_W-1:0] inverse_value);
    apb_write(adx_pkg::REG_PERIOD, adx_pkg::PDATA_W'(period_value));
    apb_write(adx_pkg::REG_INVERSE, adx_pkg::PDATA_W'(inverse_value));
    apb_read_check(adx_pkg::REG_PERIOD, adx_pkg::PDATA_W'(cfg_period));
    apb_read_check(adx_pkg::REG_INVERSE, adx_pkg::PDATA_W'(cfg_inverse));
  endtask

  function automatic logic [adx_pkg::PRICE_W-1:0] price_clip(input longint v);
    if (v < 0) begin
      return '0;
    end
    if (v > longint'(32'hFFFF_FFFF)) begin
      return '1;
    end
    return v[adx_pkg::PRICE_W-1:0];
  endfunction

  // Mostly a drifting price walk, with repeated bars and fully random noise mixed in
  task automatic make_bar(input int unsigned restart_pct, output logic restart,
                          output logic [adx_pkg::PRICE_W-1:0] hi,
                          output logic [adx_pkg::PRICE_W-1:0] lo);
    int unsigned pick;
    int unsigned spread;
    longint      step;
    pick    = $urandom_range(99);
    spread  = $urandom_range(3000);
    restart = ($urandom_range(99) < restart_pct);
    if (pick < 8) begin
      hi = $urandom();
      lo = $urandom();
    end else if (pick < 14) begin
      hi = walk_high;
      lo = walk_low;
    end else begin
      step = (pick < 17) ? longint'($urandom_range(32'h4000_0000)) :
                           longint'($urandom_range(5000));
      if ($urandom_range(1) == 0) begin
        step = -step;
      end
      walk_mid = longint'(price_clip(walk_mid + walk_drift + step));
      hi = price_clip(walk_mid + spread);
      lo = price_clip(walk_mid - spread);
    end
    walk_high = hi;
    walk_low  = lo;
  endtask

  task automatic test_reset_values();
    apb_read_check(adx_pkg::REG_PERIOD, adx_pkg::PDATA_W'(adx_pkg::PERIOD_RESET));
    apb_read_check(adx_pkg::REG_INVERSE, adx_pkg::PDATA_W'(adx_pkg::INV_RESET));
  endtask

  task automatic test_directed_bars();
    set_idling(0, 0);
    set_config(11'd2, 24'd8388608);
    // first bar after reset opens the series
    send_bar(1'b0, 100, 50);
    send_bar(1'b0, 110, 45);
    send_bar(1'b0, 120, 40);
    send_bar(1'b0, 112, 30);
    // equal up and down moves: neither counts
    send_bar(1'b0, 122, 20);
    send_bar(1'b0, 5, 500);
    // identical bars after a restart leave the directional sum at zero
    send_bar(1'b1, 200, 100);
    send_bar(1'b0, 200, 100);
    send_bar(1'b0, 200, 100);
    send_bar(1'b1, 0, 0);
    send_bar(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_bar(1'b0, 0, 0);
    send_bar(1'b0, 32'hFFFF_FFFF, 0);
    send_bar(1'b0, 0, 32'hFFFF_FFFF);
    send_bar(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    settle_block();
    // period below the minimum clamps; zero inverse means no decay
    set_config(11'd0, 24'd0);
    send_bar(1'b1, 1000, 900);
    send_bar(1'b0, 1500, 950);
    send_bar(1'b0, 2000, 1000);
    send_bar(1'b0, 2500, 1100);
    settle_block();
    // near-unity inverse pushes the index past full scale
    set_config(11'd1, 24'hFF_FFFF);
    send_bar(1'b1, 1000, 900);
    send_bar(1'b0, 900000, 899000);
    send_bar(1'b0, 1800000, 1799000);
    send_bar(1'b0, 2700000, 2699000);
    settle_block();
  endtask

  task automatic test_random_series();
    int unsigned                  pick;
    int unsigned                  p_eff;
    logic [adx_pkg::PERIOD_W-1:0] period_value;
    logic [adx_pkg::INV_W-1:0]    inverse_value;
    logic                         rs;
    logic [adx_pkg::PRICE_W-1:0]  hi;
    logic [adx_pkg::PRICE_W-1:0]  lo;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: set_idling(0, 0);
        1: set_idling(68, 0);
        2: set_idling(0, 68);
        default: set_idling(16, 16);
      endcase
      for (int chunk = 0; chunk < 5; chunk++) begin
        settle_block();
        pick = $urandom_range(99);
        if (pick < 70) begin
          period_value = adx_pkg::PERIOD_W'($urandom_range(2, 12));
        end else if (pick < 92) begin
          period_value = adx_pkg::PERIOD_W'($urandom_range(13, 40));
        end else begin
          period_value = adx_pkg::PERIOD_W'($urandom_range(1));
        end
        p_eff = (period_value < adx_pkg::MIN_PERIOD) ? adx_pkg::MIN_PERIOD : period_value;
        pick = $urandom_range(99);
        if (pick < 80) begin
          inverse_value = adx_pkg::INV_W'(((32'd1 << 24) + p_eff / 2) / p_eff);
        end else if (pick < 88) begin
          inverse_value = adx_pkg::INV_W'($urandom_range(24'hFF_FFFF));
        end else if (pick < 94) begin
          inverse_value = '0;
        end else begin
          inverse_value = '1;
        end
        set_config(period_value, inverse_value);
        walk_drift = longint'($urandom_range(1200)) - 600;
        for (int n = 0; n < 45; n++) begin
          make_bar(1, rs, hi, lo);
          send_bar(rs, hi, lo, $urandom_range(49) == 0);
        end
      end
    end
    settle_block();
  endtask

  task automatic test_long_period();
    logic                        rs;
    logic [adx_pkg::PRICE_W-1:0] hi;
    logic [adx_pkg::PRICE_W-1:0] lo;
    set_idling(16, 16);
    set_config(11'd500, 24'd33554);
    walk_drift = 300;
    make_bar(0, rs, hi, lo);
    send_bar(1'b1, hi, lo);
    for (int n = 0; n < 2 * 500 + 60; n++) begin
      make_bar(0, rs, hi, lo);
      send_bar(rs, hi, lo, $urandom_range(49) == 0);
    end
    settle_block();
    // period above the maximum clamps; the series sits between one and two periods
    set_config(11'h7FF, 24'hFF_FFFF);
    for (int n = 0; n < 20; n++) begin
      make_bar(0, rs, hi, lo);
      send_bar(rs, hi, lo);
    end
    settle_block();
    // shrink the period mid-series: every bar now gives a result
    set_config(11'd1, 24'd8388608);
    for (int n = 0; n < 20; n++) begin
      make_bar(0, rs, hi, lo);
      send_bar(rs, hi, lo);
    end
    settle_block();
  endtask

  initial begin
    rst_n             = 1'b0;
    bar_if.valid      = 1'b0;
    bar_if.restart    = 1'b0;
    bar_if.high_price = '0;
    bar_if.low_price  = '0;
    res_if.ready      = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    cfg_period        = adx_pkg::PERIOD_RESET;
    cfg_inverse       = adx_pkg::INV_RESET;
    last_high         = '0;
    last_low          = '0;
    plus_dm_sum       = '0;
    minus_dm_sum      = '0;
    dx_accum          = '0;
    bar_index         = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_values();
    test_directed_bars();
    test_random_series();
    test_long_period();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

FILE: files.f
design/adx_pkg.sv
design/adx_if.sv
design/adx_div.sv
design/average_directional_index.sv
dv/tb_average_directional_index.sv
